FILE: design/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared constants, types and word helpers of the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH      = 1024;
  localparam int WORD_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [2:0] OP_QUERY      = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK   = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [WORD_WIDTH-1:0] word_t;

  typedef struct packed {
    logic  we;
    idx_t  waddr;
    word_t wdata;
    logic  re;
    idx_t  raddr;
  } ram_req_t;

  function automatic idx_t ring_inc(idx_t i);
    return (32'(i) + 32'd1 >= 32'(DEPTH)) ? '0 : i + idx_t'(1);
  endfunction

  function automatic idx_t ring_dec(idx_t i);
    return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
  endfunction

  // 32-bit input word, sign extended, then kept in WORD_WIDTH bits
  function automatic word_t to_word(logic [31:0] v);
    logic [63:0] e;
    e = {{32{v[31]}}, v};
    return e[WORD_WIDTH-1:0];
  endfunction

  // stored word sign extended from WORD_WIDTH bits, shown in 32 bits
  function automatic logic [31:0] word_out(word_t w);
    logic [63:0] e;
    e = {64{w[WORD_WIDTH-1]}};
    e[WORD_WIDTH-1:0] = w;
    return e[31:0];
  endfunction

endpackage

FILE: design/deq_ram.sv
// ----------------------------------------------------------------------------
// deq_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram (
  input  logic              clk,
  input  deq_pkg::ram_req_t req,
  output deq_pkg::word_t    rd_data
);
  import deq_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

FILE: design/double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// In each transaction, start is taken while busy is low, busy
// stays high for the one cycle in which the entry memory delivers the new
// front or back word, and the result is strobed on out_valid for exactly one
// cycle after that. A new transaction may be started in that same cycle. The
// result cannot be stalled by the receiver. The words at the front and back
// are held in registers, so only a pop reads the memory. No clearing pass
// runs after reset; the queue is ready on the first cycle.
// ----------------------------------------------------------------------------
module double_ended_queue_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [2:0]            in_opcode,
  input  logic signed [31:0]    in_value,
  output logic                  out_valid,
  output logic signed [31:0]    out_popped_value,
  output logic [1:0]            out_status,
  output logic [deq_pkg::CNT_W-1:0] out_count,
  output logic                  out_is_empty,
  output logic signed [31:0]    out_front_value,
  output logic signed [31:0]    out_back_value
);
  import deq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_WAIT = 2'b10
  } state_t;

  state_t   state_r, state_nxt;
  idx_t     front_idx_r, front_idx_nxt;
  idx_t     back_idx_r, back_idx_nxt;
  cnt_t     count_r, count_nxt;
  word_t    front_r, front_nxt;
  word_t    back_r, back_nxt;
  logic     ld_front_r, ld_front_nxt;
  logic     ld_back_r, ld_back_nxt;
  logic     valid_r;
  logic [31:0] popped_r, popped_nxt;
  logic [1:0]  status_r, status_nxt;
  logic     empty_out_r;
  logic [31:0] front_out_r, back_out_r;
  ram_req_t ram_req;
  word_t    rd_data;
  word_t    word_in;
  logic     accept;

  deq_ram u_ram (
    .clk    (clk),
    .req    (ram_req),
    .rd_data(rd_data)
  );

  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign word_in = to_word(in_value);

  always_comb begin
    state_nxt     = state_r;
    front_idx_nxt = front_idx_r;
    back_idx_nxt  = back_idx_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    back_nxt      = back_r;
    ld_front_nxt  = ld_front_r;
    ld_back_nxt   = ld_back_r;
    popped_nxt    = '1;
    status_nxt    = ST_DONE;
    ram_req       = '0;
    ram_req.wdata = word_in;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt    = S_WAIT;
          ld_front_nxt = 1'b0;
          ld_back_nxt  = 1'b0;
          case (in_opcode)
            OP_PUSH_FRONT: begin
              if (count_r == cnt_t'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                front_idx_nxt = ring_dec(front_idx_r);
                ram_req.we    = 1'b1;
                ram_req.waddr = front_idx_nxt;
                count_nxt     = count_r + cnt_t'(1);
                front_nxt     = word_in;
                if (count_r == '0) begin
                  back_nxt = word_in;
                end
              end
            end
            OP_PUSH_BACK: begin
              if (count_r == cnt_t'(DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = back_idx_r;
                back_idx_nxt  = ring_inc(back_idx_r);
                count_nxt     = count_r + cnt_t'(1);
                back_nxt      = word_in;
                if (count_r == '0) begin
                  front_nxt = word_in;
                end
              end
            end
            OP_POP_FRONT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                popped_nxt    = word_out(front_r);
                front_idx_nxt = ring_inc(front_idx_r);
                count_nxt     = count_r - cnt_t'(1);
                // new front word arrives from memory next cycle
                ram_req.re    = 1'b1;
                ram_req.raddr = front_idx_nxt;
                ld_front_nxt  = 1'b1;
              end
            end
            OP_POP_BACK: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                popped_nxt    = word_out(back_r);
                back_idx_nxt  = ring_dec(back_idx_r);
                count_nxt     = count_r - cnt_t'(1);
                ram_req.re    = 1'b1;
                ram_req.raddr = ring_dec(back_idx_nxt);
                ld_back_nxt   = 1'b1;
              end
            end
            default: begin
              // query and unused codes change nothing
            end
          endcase
        end
      end
      S_WAIT: begin
        state_nxt = S_IDLE;
        if (ld_front_r) begin
          front_nxt = rd_data;
        end
        if (ld_back_r) begin
          back_nxt = rd_data;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_idx_r <= '0;
      back_idx_r  <= '0;
      count_r     <= '0;
      ld_front_r  <= 1'b0;
      ld_back_r   <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_idx_r <= front_idx_nxt;
      back_idx_r  <= back_idx_nxt;
      count_r     <= count_nxt;
      ld_front_r  <= ld_front_nxt;
      ld_back_r   <= ld_back_nxt;
      valid_r     <= (state_r == S_WAIT);
    end
  end

  always_ff @(posedge clk) begin
    front_r <= front_nxt;
    back_r  <= back_nxt;
    if (accept) begin
      popped_r <= popped_nxt;
      status_r <= status_nxt;
    end
    if (state_r == S_WAIT) begin
      empty_out_r <= (count_r == '0);
      front_out_r <= (count_r == '0) ? '1 : word_out(front_nxt);
      back_out_r  <= (count_r == '0) ? '1 : word_out(back_nxt);
    end
  end

  // count is already final during the wait cycle and stays so while shown
  assign out_valid        = valid_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_count        = count_r;
  assign out_is_empty     = empty_out_r;
  assign out_front_value  = front_out_r;
  assign out_back_value   = back_out_r;

endmodule

FILE: design/deq_checker.sv
// ----------------------------------------------------------------------------
// deq_checker
// Port-level checks of the double-ended queue, bound to the top level.
// ----------------------------------------------------------------------------
module deq_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [1:0]                out_status,
  input logic [deq_pkg::CNT_W-1:0] out_count,
  input logic                      out_is_empty,
  input logic [31:0]               out_front_value,
  input logic [31:0]               out_back_value
);
  import deq_pkg::*;

  // every accepted transaction raises busy and then strobes its result
  a_result_timing: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 out_valid)
    else $error("result not strobed two cycles after transaction");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result strobed without a transaction");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_is_empty == (out_count == '0)) && (out_count <= cnt_t'(DEPTH)))
    else $error("empty flag or count inconsistent");

  a_empty_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_empty) |-> (out_front_value == '1) && (out_back_value == '1))
    else $error("empty queue shows words");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_DONE) || (out_status == ST_EMPTY) ||
                  (out_status == ST_FULL))
    else $error("undefined status code");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_count      (out_count),
  .out_is_empty   (out_is_empty),
  .out_front_value(out_front_value),
  .out_back_value (out_back_value)
);

FILE: tb/tb_double_ended_queue_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue_unit
// Drives push, pop and query transactions into the double-ended queue and
// checks every result against a ring-buffer model kept in the testbench.
// Covers empty pops, index wrap at both ends and the unused opcodes.
// ----------------------------------------------------------------------------
module tb_double_ended_queue_unit;
  import deq_pkg::*;

  localparam logic [2:0] OP_SPARE_FIRST = OP_POP_BACK + 3'd1;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
  localparam logic [31:0] WORD_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
  localparam logic [31:0] WORD_ALL_ONES = 32'hFFFF_FFFF;
  localparam int RANDOM_OPS   = 720;
  localparam int SEGMENT_OPS  = 150;
  localparam int MAX_REPORTS  = 10;
  localparam int TAIL_CYCLES  = 8;
  localparam int MAX_OPS      = 1024;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] value;
  } deque_op_t;

  typedef struct packed {
    logic [31:0] popped_value;
    logic [1:0]  status;
    cnt_t        count;
    logic        is_empty;
    logic [31:0] front_value;
    logic [31:0] back_value;
  } deque_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [2:0]                in_opcode;
  logic signed [31:0]        in_value;
  logic                      out_valid;
  logic signed [31:0]        out_popped_value;
  logic [1:0]                out_status;
  logic [CNT_W-1:0]          out_count;
  logic                      out_is_empty;
  logic signed [31:0]        out_front_value;
  logic signed [31:0]        out_back_value;

  double_ended_queue_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_count        (out_count),
    .out_is_empty     (out_is_empty),
    .out_front_value  (out_front_value),
    .out_back_value   (out_back_value)
  );

  // pending transactions and expected results, each a list with read/write marks
  deque_op_t     op_list[MAX_OPS];
  int            op_fill;
  int            op_next;
  deque_result_t due_list[MAX_OPS];
  int            due_wr;
  int            due_rd;
  int            total_ops;
  int            issued_cnt;
  int            taken_cnt;
  int            fail_cnt;

  // ring model of the queue contents
  word_t ring_words[DEPTH];
  int    head_idx;
  int    tail_idx;
  int    words_held;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic apply_deque_op(input logic [2:0] op, input logic [31:0] val);
    deque_result_t r;
    r.popped_value = WORD_ALL_ONES;
    r.status       = ST_DONE;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (words_held >= DEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_PUSH_FRONT) begin
          head_idx = (head_idx + DEPTH - 1) % DEPTH;
          ring_words[head_idx] = word_t'(val);
          words_held++;
        end else begin
          ring_words[tail_idx] = word_t'(val);
          tail_idx = (tail_idx + 1) % DEPTH;
          words_held++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (words_held == 0) begin
          r.status = ST_EMPTY;
        end else if (op == OP_POP_FRONT) begin
          r.popped_value = 32'(signed'(ring_words[head_idx]));
          head_idx = (head_idx + 1) % DEPTH;
          words_held--;
        end else begin
          tail_idx = (tail_idx + DEPTH - 1) % DEPTH;
          r.popped_value = 32'(signed'(ring_words[tail_idx]));
          words_held--;
        end
      end
      default: ;  // query and spare opcodes leave the queue alone
    endcase
    r.count    = cnt_t'(words_held);
    r.is_empty = (words_held == 0);
    if (words_held == 0) begin
      r.front_value = WORD_ALL_ONES;
      r.back_value  = WORD_ALL_ONES;
    end else begin
      r.front_value = 32'(signed'(ring_words[head_idx]));
      r.back_value  = 32'(signed'(ring_words[(tail_idx + DEPTH - 1) % DEPTH]));
    end
    due_list[due_wr] = r;
    due_wr++;
  endtask

  // driver: a new transaction is offered once the previous one was taken
  always @(negedge clk) begin : drive
    deque_op_t nxt;
    int        idle_pct;
    if (!rst_n) begin
      start     <= 1'b0;
      in_opcode <= OP_QUERY;
      in_value  <= '0;
    end else if (taken_cnt == issued_cnt) begin
      if (issued_cnt < total_ops / 3)
        idle_pct = 6;
      else if (issued_cnt < 2 * total_ops / 3)
        idle_pct = 49;
      else
        idle_pct = 0;
      if (op_next < op_fill && $urandom_range(99) >= idle_pct) begin
        nxt = op_list[op_next];
        op_next++;
        start      <= 1'b1;
        in_opcode  <= nxt.opcode;
        in_value   <= nxt.value;
        issued_cnt <= issued_cnt + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // acceptance and result checking
  always @(posedge clk) begin : observe
    deque_result_t got;
    deque_result_t want;
    if (rst_n && out_valid) begin
      got = '{out_popped_value, out_status, out_count, out_is_empty,
              out_front_value, out_back_value};
      if (due_rd == due_wr) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: unexpected result %p", $realtime, got);
      end else begin
        want = due_list[due_rd];
        due_rd++;
        if (got.popped_value !== want.popped_value || got.status !== want.status ||
            got.count !== want.count || got.is_empty !== want.is_empty ||
            got.front_value !== want.front_value ||
            got.back_value !== want.back_value) begin
          fail_cnt++;
          if (fail_cnt <= MAX_REPORTS)
            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
        end
      end
    end
    if (rst_n && start && !busy) begin
      apply_deque_op(in_opcode, in_value);
      taken_cnt <= taken_cnt + 1;
    end
  end

  task automatic add_op(input logic [2:0] op, input logic [31:0] val);
    if (op_fill < MAX_OPS) begin
      op_list[op_fill] = '{op, val};
      op_fill++;
    end
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(19))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return WORD_ALL_ONES;
      3:       return '0;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int push_pct;
    int roll;
    start      = 1'b0;
    in_opcode  = OP_QUERY;
    in_value   = '0;
    rst_n      = 1'b0;
    op_fill    = 0;
    op_next    = 0;
    due_wr     = 0;
    due_rd     = 0;
    issued_cnt = 0;
    taken_cnt  = 0;
    fail_cnt   = 0;
    head_idx   = 0;
    tail_idx   = 0;
    words_held = 0;

    // directed: empty queue, extremes, both ends, spare opcodes
    add_op(OP_QUERY, '0);
    add_op(OP_POP_FRONT, WORD_MAX);
    add_op(OP_POP_BACK, WORD_MIN);
    add_op(OP_PUSH_FRONT, WORD_MAX);
    add_op(OP_PUSH_BACK, WORD_MIN);
    add_op(OP_PUSH_FRONT, WORD_ALL_ONES);
    add_op(OP_PUSH_BACK, '0);
    add_op(OP_QUERY, WORD_ALL_ONES);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      add_op(op[2:0], 32'h5A5A_A5A5);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_BACK, '0);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_BACK, '0);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_POP_BACK, '0);
    add_op(OP_PUSH_BACK, 32'h0000_0001);
    add_op(OP_POP_FRONT, '0);
    add_op(OP_PUSH_FRONT, 32'hFFFF_FFFE);
    add_op(OP_POP_BACK, '0);

    // random mix, push bias swings so the count wanders up and down
    for (int i = 0; i < RANDOM_OPS; i++) begin
      push_pct = ((i / SEGMENT_OPS) % 2 == 0) ? 65 : 35;
      roll = $urandom_range(99);
      if (roll < 4)
        add_op(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), pick_word());
      else if (roll < 10)
        add_op(OP_QUERY, pick_word());
      else if ($urandom_range(99) < push_pct)
        add_op($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_word());
      else
        add_op($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, pick_word());
    end
    total_ops = op_fill;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (op_next < op_fill || taken_cnt != issued_cnt)
      @(posedge clk);
    while (due_rd != due_wr)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_cnt == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
